@@ rtl/core/boli_pkg.sv @@
// Shared types and constants for the bounded ordered list block.
package boli_pkg;

    // Default number of list cells.
    localparam int CAPACITY_DEF = 16;

    // Fixed field widths of the request and result.
    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Operation codes carried by a request.
    typedef enum logic [OP_W-1:0] {
        OP_END   = 2'd0,
        OP_FRONT = 2'd1,
        OP_DEL   = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic              cmp;     // compare cycle: latch key match
        logic              upd;     // update cycle: move values
        logic              ins_ok;  // insert is allowed (list not full)
        t_op               op;
        logic [DATA_W-1:0] key;
    } t_cell_ctl;

endpackage

@@ rtl/core/boli_cell.sv @@
// One cell of the list row: holds one entry and shifts towards its neighbours.
module boli_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  boli_pkg::t_cell_ctl        i_ctl,
    input  logic                       i_live,
    input  logic                       i_tail,
    input  logic                       i_hit,
    input  logic [boli_pkg::DATA_W-1:0] i_prev_val,
    input  logic [boli_pkg::DATA_W-1:0] i_next_val,
    output logic                       o_hit,
    output logic [boli_pkg::DATA_W-1:0] o_val,
    output logic [boli_pkg::DATA_W-1:0] o_next_val
);
    import boli_pkg::*;

    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] n_val;
    logic              r_match;

    // A match here or anywhere nearer the head removes or shifts this entry.
    assign o_hit = i_hit | r_match;

    // Next value of the entry for the requested operation.
    always_comb begin
        n_val = r_val;
        if (i_ctl.upd) begin
            case (i_ctl.op)
                OP_END: begin
                    if (i_ctl.ins_ok && i_tail) n_val = i_ctl.key;
                end
                OP_FRONT: begin
                    if (i_ctl.ins_ok) n_val = i_prev_val;
                end
                OP_DEL: begin
                    if (o_hit) n_val = i_next_val;
                end
                default: begin
                    n_val = r_val;
                end
            endcase
        end
    end

    assign o_next_val = n_val;
    assign o_val      = r_val;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    // Key compare result, held until the following update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_match <= i_live && (r_val == i_ctl.key);
        end
    end

endmodule

@@ rtl/core/bounded_ordered_list_insert_delete.sv @@
// Each request runs as a key compare in every cell, then one shift of the row.
// The result register is loaded when the shift state, which follows the compare state, completes.
// A request is taken in the shift cycle of the previous one unless the result register is blocked.
// Synchronous active-low reset empties the list and clears control; cell contents stay undefined.
module bounded_ordered_list_insert_delete #(
    parameter int CAPACITY = boli_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [boli_pkg::OP_W-1:0]    i_op,
    input  logic [boli_pkg::DATA_W-1:0]  i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [boli_pkg::STAT_W-1:0]  o_status,
    output logic [boli_pkg::COUNT_W-1:0] o_entry_count,
    output logic                         o_head_valid,
    output logic [boli_pkg::DATA_W-1:0]  o_head_value
);
    import boli_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    t_op                 r_op;
    logic [DATA_W-1:0]   r_value;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [CNT_W+4:0]    w_count_ext;

    logic                r_out_valid;
    t_status             r_status;
    t_status             n_status;
    logic [COUNT_W-1:0]  r_entry_count;
    logic                r_head_valid;
    logic [DATA_W-1:0]   r_head_value;

    logic                w_in_take;
    logic                w_out_block;
    logic                w_upd_fire;
    logic                w_full;
    logic                w_found;
    t_cell_ctl           w_ctl;

    logic [DATA_W-1:0]   w_val  [CAPACITY];
    logic [DATA_W-1:0]   w_next [CAPACITY];
    logic [CAPACITY:0]   w_hit;

    // Handshake and sequencing.
    assign w_out_block = r_out_valid && i_out_stall;
    assign w_upd_fire  = (r_state == S_UPD) && !w_out_block;
    assign o_in_stall  = (r_state == S_CMP) || ((r_state == S_UPD) && w_out_block);
    assign w_in_take   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_take) n_state = S_CMP;
            S_CMP:  n_state = S_UPD;
            S_UPD: begin
                if (w_upd_fire) n_state = w_in_take ? S_CMP : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op    <= t_op'(i_op);
            r_value <= i_value;
        end
    end

    // Broadcast control for the cell row.
    assign w_full = (r_count >= CNT_W'(CAPACITY));
    always_comb begin
        w_ctl.cmp    = (r_state == S_CMP);
        w_ctl.upd    = w_upd_fire;
        w_ctl.ins_ok = !w_full;
        w_ctl.op     = r_op;
        w_ctl.key    = r_value;
    end

    // Row of cells, head at index zero.
    assign w_hit[0] = 1'b0;
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [DATA_W-1:0] w_prev_in;
            logic [DATA_W-1:0] w_next_in;
            if (gi == 0) begin : g_head
                assign w_prev_in = r_value;
            end else begin : g_body
                assign w_prev_in = w_val[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_next_in = '0;
            end else begin : g_inner
                assign w_next_in = w_val[gi+1];
            end
            boli_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_live     (r_count > CNT_W'(gi)),
                .i_tail     (r_count == CNT_W'(gi)),
                .i_hit      (w_hit[gi]),
                .i_prev_val (w_prev_in),
                .i_next_val (w_next_in),
                .o_hit      (w_hit[gi+1]),
                .o_val      (w_val[gi]),
                .o_next_val (w_next[gi])
            );
        end
    endgenerate

    assign w_found = w_hit[CAPACITY];

    // Status and count after the operation.
    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        case (r_op) inside
            OP_END, OP_FRONT: begin
                if (w_full) n_status = ST_FULL;
                else        n_count  = r_count + CNT_W'(1);
            end
            OP_DEL: begin
                if (w_found) n_count  = r_count - CNT_W'(1);
                else         n_status = ST_MISS;
            end
            default: n_status = ST_OK;
        endcase
    end

    assign w_count_ext = (CNT_W + 5)'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_upd_fire) begin
            r_count <= n_count;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_upd_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd_fire) begin
            r_status      <= n_status;
            r_entry_count <= w_count_ext[COUNT_W-1:0];
            r_head_valid  <= (n_count != '0);
            r_head_value  <= (n_count != '0) ? w_next[0] : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;
    assign o_head_valid  = r_head_valid;
    assign o_head_value  = r_head_value;

    // The count never passes the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A match can only come from an occupied cell.
    a_hit_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) && w_found |-> r_count != '0)
        else $error("key match in an empty list");

    // A successful delete removes exactly one entry.
    a_del_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd_fire && (r_op == OP_DEL) && w_found |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("delete did not shrink the list by one");

    // An accepted insert grows the list by one.
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd_fire && ((r_op == OP_END) || (r_op == OP_FRONT)) && !w_full
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the list by one");

    // The result register is only loaded from the update cycle.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_UPD))
        else $error("result raised outside the update cycle");

endmodule

@@ sim/tb_bounded_ordered_list_insert_delete.sv @@
// Self-checking testbench for the bounded ordered list with insert and delete requests.
`timescale 1ns / 100ps

module tb_bounded_ordered_list_insert_delete;
    import boli_pkg::*;

    localparam int LIST_CAPACITY = CAPACITY_DEF;
    localparam int HOLD_CYCLES   = 64;
    localparam int QUIET_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;

    // One result as the list reports it after a request.
    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] entry_count;
        logic               head_valid;
        logic [DATA_W-1:0]  head_value;
    } t_list_result;

    // Scoreboard: keeps its own copy of the list and the results still owed by the block.
    class ordered_list_board;
        logic [DATA_W-1:0] stored[$];
        t_list_result      expected_results[$];
        int                errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Apply an accepted request to the list copy and queue the result it must give.
        function void note_request(t_op op, logic [DATA_W-1:0] value);
            t_list_result r;
            int           hit;
            hit = -1;
            r.status = ST_OK;
            case (op)
                OP_END: begin
                    if (stored.size() >= LIST_CAPACITY) r.status = ST_FULL;
                    else stored.push_back(value);
                end
                OP_FRONT: begin
                    if (stored.size() >= LIST_CAPACITY) r.status = ST_FULL;
                    else stored.push_front(value);
                end
                OP_DEL: begin
                    for (int i = 0; i < stored.size(); i++) begin
                        if (hit < 0 && stored[i] == value) hit = i;
                    end
                    if (hit < 0) r.status = ST_MISS;
                    else stored.delete(hit);
                end
                default: ;
            endcase
            r.entry_count = COUNT_W'(stored.size());
            r.head_valid  = (stored.size() > 0);
            r.head_value  = (stored.size() > 0) ? stored[0] : '0;
            expected_results.push_back(r);
        endfunction

        // Compare an accepted result with the oldest outstanding expectation.
        function void check_result(logic [STAT_W-1:0] status, logic [COUNT_W-1:0] entry_count,
                                   logic head_valid, logic [DATA_W-1:0] head_value);
            t_list_result r;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: result with no request outstanding", $time);
                return;
            end
            r = expected_results.pop_front();
            if (status !== r.status || entry_count !== r.entry_count ||
                head_valid !== r.head_valid || head_value !== r.head_value) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display({"%0t: mismatch: status %0d/%0d, count %0d/%0d, ",
                              "head_valid %0b/%0b, head %h/%h (expected/actual)"},
                             $time, r.status, status, r.entry_count, entry_count,
                             r.head_valid, head_valid, r.head_value, head_value);
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_op = OP_END;
    logic [DATA_W-1:0]   i_value = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [STAT_W-1:0]   o_status;
    logic [COUNT_W-1:0]  o_entry_count;
    logic                o_head_valid;
    logic [DATA_W-1:0]   o_head_value;

    ordered_list_board board;
    int unsigned       in_idle_pct = 0;
    int unsigned       out_idle_pct = 0;
    int                holds_asked = 0;
    int                holds_started = 0;
    int                hold_left = 0;
    int                quiet_cycles = 0;
    bit                list_draining = 1'b0;

    bounded_ordered_list_insert_delete #(
        .CAPACITY(LIST_CAPACITY)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_op(i_op),
        .i_value(i_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status(o_status),
        .o_entry_count(o_entry_count),
        .o_head_valid(o_head_valid),
        .o_head_value(o_head_value)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result side back-pressure: a long hold-off when asked, otherwise random stalls.
    always @(posedge i_clk) begin
        if (holds_started != holds_asked) begin
            holds_started <= holds_asked;
            hold_left     <= HOLD_CYCLES;
            i_out_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // Results are checked mid-cycle, when outputs and stall are settled for the next edge.
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(o_status, o_entry_count, o_head_valid, o_head_value);
    end

    // Watchdog on cycles in which neither channel moves a request or a result.
    always @(negedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request, with a random gap first, and hold it until the block takes it.
    task automatic send_request(input t_op op, input logic [DATA_W-1:0] value);
        if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= value;
        do @(negedge i_clk); while (o_in_stall);
        board.note_request(op, value);
        @(posedge i_clk);
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Edge values, both insert ends, deletes at head, middle and tail, misses and a full list.
    task automatic directed_requests();
        send_request(OP_DEL, 32'd5);
        send_request(OP_END, 32'h7FFF_FFFF);
        send_request(OP_FRONT, 32'h8000_0000);
        send_request(OP_END, 32'h0000_0000);
        send_request(OP_END, 32'hFFFF_FFFF);
        send_request(OP_DEL, 32'd1234);
        send_request(OP_DEL, 32'hFFFF_FFFF);
        send_request(OP_DEL, 32'h8000_0000);
        send_request(OP_NONE, 32'h5A5A_A5A5);
        // Fill to capacity with repeated values so that a later delete hits the first copy.
        for (int k = 0; k < LIST_CAPACITY - 2; k++)
            send_request(k[0] ? OP_END : OP_FRONT, 32'd100 + 32'(k % 4));
        send_request(OP_END, 32'hDEAD_BEEF);
        send_request(OP_FRONT, 32'hDEAD_BEEF);
        send_request(OP_DEL, 32'd101);
        send_request(OP_DEL, 32'h7FFF_FFFF);
        send_request(OP_NONE, 32'h0);
    endtask

    // Random requests that swing the list between empty and full, mostly deleting held keys.
    task automatic random_requests(input int n);
        t_op               op;
        logic [DATA_W-1:0] value;
        int unsigned       roll;
        for (int k = 0; k < n; k++) begin
            if (board.stored.size() >= LIST_CAPACITY) list_draining = 1'b1;
            else if (board.stored.size() == 0) list_draining = 1'b0;
            roll = $urandom_range(99);
            if (roll < 5) op = OP_NONE;
            else if (roll < (list_draining ? 70 : 30)) op = OP_DEL;
            else op = $urandom_range(1) ? OP_FRONT : OP_END;
            roll = $urandom_range(99);
            if (op == OP_DEL && board.stored.size() > 0 && roll < 70) begin
                value = board.stored[$urandom_range(board.stored.size() - 1)];
            end else if (roll < 80) begin
                value = $urandom;
            end else if (roll < 90) begin
                value = 32'($urandom_range(8)) - 32'd4;
            end else begin
                case ($urandom_range(3))
                    0: value = 32'h8000_0000;
                    1: value = 32'h7FFF_FFFF;
                    2: value = 32'h0000_0000;
                    default: value = 32'hFFFF_FFFF;
                endcase
            end
            send_request(op, value);
        end
    endtask

    // Test sequence.
    initial begin
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles lightly, receiver heavily.
        in_idle_pct  = 23;
        out_idle_pct = 66;
        directed_requests();
        random_requests(260);
        wait_for_results();

        // The other way round.
        in_idle_pct  = 66;
        out_idle_pct = 23;
        random_requests(260);
        wait_for_results();

        // No idling; first a long receiver hold-off while requests keep coming.
        in_idle_pct  = 0;
        out_idle_pct = 0;
        holds_asked  = holds_asked + 1;
        random_requests(12);
        wait_for_results();
        random_requests(260);
        wait_for_results();

        repeat (8) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/boli_pkg.sv
rtl/core/boli_cell.sv
rtl/core/bounded_ordered_list_insert_delete.sv
sim/tb_bounded_ordered_list_insert_delete.sv
